// ----- rtl/core/tixc_pkg.sv -----
package tixc_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int MAX_BINS_DEF = 1024;

	localparam int PROD_W    = 2 * SAMPLE_BITS;
	localparam int TERM_W    = PROD_W + 1;
	localparam int POW_W     = 47;
	localparam int XC_W      = 48;
	localparam int BIN_OUT_W = 10;
	localparam int CNT_W     = 16;
	localparam int NBINS_W   = 11;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SPECTRA_PER_DUMP = CFG_IDX_W'(1);

	localparam logic [NBINS_W-1:0] NBINS_RST = NBINS_W'(1024);
	localparam logic [CNT_W-1:0]   NSPEC_RST = CNT_W'(1024);

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = 3;
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
	localparam int OCC_W      = FIFO_CNT_W + 1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] a_re;
		logic signed [SAMPLE_BITS-1:0] a_im;
		logic signed [SAMPLE_BITS-1:0] b_re;
		logic signed [SAMPLE_BITS-1:0] b_im;
	} sample_t;

	typedef struct packed {
		logic        [BIN_OUT_W-1:0] bin_index;
		logic        [POW_W-1:0]     power_a;
		logic        [POW_W-1:0]     power_b;
		logic signed [XC_W-1:0]      cross_real;
		logic signed [XC_W-1:0]      cross_imag;
		logic        [CNT_W-1:0]     spectra_count;
		logic                        last_bin;
	} result_t;

	typedef struct packed {
		logic [POW_W-1:0] pa;
		logic [POW_W-1:0] pb;
		logic [XC_W-1:0]  cr;
		logic [XC_W-1:0]  ci;
	} acc_t;

	typedef struct packed {
		logic             is_final;
		logic             end_spec;
		logic [CNT_W-1:0] count;
	} tag_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] pa;
		logic signed [TERM_W-1:0] pb;
		logic signed [TERM_W-1:0] cr;
		logic signed [TERM_W-1:0] ci;
	} terms_t;

endpackage

// ----- rtl/core/tixc_seq.sv -----
module tixc_seq import tixc_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [NBINS_W-1:0]          nbins,
	input  logic [CNT_W-1:0]            nspec,
	output logic [$clog2(MAX_BINS)-1:0] bin,
	output tag_t                        tag
);

	localparam int IDX_W = $clog2(MAX_BINS);

	logic [IDX_W-1:0] bin_q;
	logic [CNT_W-1:0] spec_q;
	logic [IDX_W-1:0] last_bin;
	logic [CNT_W-1:0] last_spec;

	// zero bins acts as one, too many saturates
	always_comb begin
		if (nbins == '0) begin
			last_bin = '0;
		end else if (32'(nbins) > 32'(MAX_BINS)) begin
			last_bin = IDX_W'(MAX_BINS - 1);
		end else begin
			last_bin = IDX_W'(nbins - NBINS_W'(1));
		end
		last_spec = (nspec == '0) ? '0 : nspec - CNT_W'(1);
	end

	assign bin          = bin_q;
	assign tag.end_spec = (bin_q >= last_bin);
	assign tag.is_final = (spec_q >= last_spec);
	assign tag.count    = spec_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			spec_q <= '0;
		end else if (accept) begin
			if (tag.end_spec) begin
				bin_q  <= '0;
				spec_q <= tag.is_final ? '0 : spec_q + CNT_W'(1);
			end else begin
				bin_q <= bin_q + IDX_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/tixc_mult.sv -----
module tixc_mult import tixc_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  sample_t                     smp,
	input  logic [$clog2(MAX_BINS)-1:0] bin,
	input  tag_t                        tag,
	output logic                        v_s1,
	output logic                        v_s2,
	output logic [$clog2(MAX_BINS)-1:0] bin_s2,
	output tag_t                        tag_s2,
	output terms_t                      terms_s2
);

	localparam int IDX_W = $clog2(MAX_BINS);

	logic signed [PROD_W-1:0] ar_ar_s1, ai_ai_s1, br_br_s1, bi_bi_s1;
	logic signed [PROD_W-1:0] ar_br_s1, ai_bi_s1, ai_br_s1, bi_ar_s1;
	logic [IDX_W-1:0]         bin_s1;
	tag_t                     tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ar_ar_s1 <= PROD_W'(smp.a_re) * PROD_W'(smp.a_re);
		ai_ai_s1 <= PROD_W'(smp.a_im) * PROD_W'(smp.a_im);
		br_br_s1 <= PROD_W'(smp.b_re) * PROD_W'(smp.b_re);
		bi_bi_s1 <= PROD_W'(smp.b_im) * PROD_W'(smp.b_im);
		ar_br_s1 <= PROD_W'(smp.a_re) * PROD_W'(smp.b_re);
		ai_bi_s1 <= PROD_W'(smp.a_im) * PROD_W'(smp.b_im);
		ai_br_s1 <= PROD_W'(smp.a_im) * PROD_W'(smp.b_re);
		bi_ar_s1 <= PROD_W'(smp.b_im) * PROD_W'(smp.a_re);
		bin_s1   <= bin;
		tag_s1   <= tag;
	end

	always_ff @(posedge clk) begin
		terms_s2.pa <= {ar_ar_s1[PROD_W-1], ar_ar_s1} + {ai_ai_s1[PROD_W-1], ai_ai_s1};
		terms_s2.pb <= {br_br_s1[PROD_W-1], br_br_s1} + {bi_bi_s1[PROD_W-1], bi_bi_s1};
		terms_s2.cr <= {ar_br_s1[PROD_W-1], ar_br_s1} + {ai_bi_s1[PROD_W-1], ai_bi_s1};
		terms_s2.ci <= {ai_br_s1[PROD_W-1], ai_br_s1} - {bi_ar_s1[PROD_W-1], bi_ar_s1};
		bin_s2      <= bin_s1;
		tag_s2      <= tag_s1;
	end

endmodule

// ----- rtl/core/tixc_accum.sv -----
module tixc_accum import tixc_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        v_s2,
	input  logic [$clog2(MAX_BINS)-1:0] bin_s2,
	input  tag_t                        tag_s2,
	input  terms_t                      terms_s2,
	output logic                        v_s3,
	output logic                        push,
	output result_t                     res,
	output logic                        busy
);

	localparam int IDX_W = $clog2(MAX_BINS);

	acc_t             mem [MAX_BINS];
	acc_t             rd_q;
	acc_t             wdata_q;
	logic             fwd_q;
	logic [IDX_W-1:0] bin_s3;
	tag_t             tag_s3;
	terms_t           terms_s3;
	logic             clr_q;
	logic [IDX_W-1:0] clr_idx_q;

	acc_t             old_acc;
	acc_t             new_acc;
	acc_t             wr_acc;
	logic             we;
	logic [IDX_W-1:0] waddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			fwd_q     <= 1'b0;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else begin
			v_s3  <= v_s2;
			// entry being written now is the one read now: the read returns stale data
			fwd_q <= v_s2 && v_s3 && (bin_s2 == bin_s3);
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(MAX_BINS - 1)) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		bin_s3   <= bin_s2;
		tag_s3   <= tag_s2;
		terms_s3 <= terms_s2;
		if (v_s3) begin
			wdata_q <= wr_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wr_acc;
		end
		if (v_s2) begin
			rd_q <= mem[bin_s2];
		end
	end

	always_comb begin
		old_acc    = fwd_q ? wdata_q : rd_q;
		new_acc.pa = old_acc.pa + {{(POW_W-TERM_W){terms_s3.pa[TERM_W-1]}}, terms_s3.pa};
		new_acc.pb = old_acc.pb + {{(POW_W-TERM_W){terms_s3.pb[TERM_W-1]}}, terms_s3.pb};
		new_acc.cr = old_acc.cr + {{(XC_W-TERM_W){terms_s3.cr[TERM_W-1]}}, terms_s3.cr};
		new_acc.ci = old_acc.ci + {{(XC_W-TERM_W){terms_s3.ci[TERM_W-1]}}, terms_s3.ci};

		// a dump, or the clear sweep after reset, zeroes the bin
		if (clr_q || tag_s3.is_final) begin
			wr_acc = '0;
		end else begin
			wr_acc = new_acc;
		end
		we    = clr_q || v_s3;
		waddr = clr_q ? clr_idx_q : bin_s3;

		res.bin_index     = BIN_OUT_W'(bin_s3);
		res.power_a       = new_acc.pa;
		res.power_b       = new_acc.pb;
		res.cross_real    = new_acc.cr;
		res.cross_imag    = new_acc.ci;
		res.spectra_count = tag_s3.count;
		res.last_bin      = tag_s3.end_spec;
	end

	assign push = v_s3 && tag_s3.is_final;
	assign busy = clr_q;

endmodule

// ----- rtl/core/tixc_fifo.sv -----
module tixc_fifo import tixc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  result_t               wdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data,
	output logic [FIFO_CNT_W-1:0] count
);

	result_t               buf_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/two_input_cross_correlator.sv -----
// path: a dump transaction passes registers s1, s2 and s3 and the output fifo to out_valid
// throughput: one input item per cycle while in_ready is high; the accumulator memory is
// read and written in the same cycle (same-bin back-to-back updates are forwarded)
// reset: after arst_n is released the accumulator memory is zeroed one bin per cycle,
// all MAX_BINS bins, with in_ready low; configuration writes are taken throughout
module two_input_cross_correlator import tixc_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sample_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_BINS);

	logic [NBINS_W-1:0]    nbins_q;
	logic [CNT_W-1:0]      nspec_q;
	logic                  accept;
	logic [IDX_W-1:0]      bin;
	tag_t                  tag;
	logic                  v_s1;
	logic                  v_s2;
	logic [IDX_W-1:0]      bin_s2;
	tag_t                  tag_s2;
	terms_t                terms_s2;
	logic                  v_s3;
	logic                  push;
	result_t               res;
	logic                  busy;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [OCC_W-1:0]      occ;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbins_q <= NBINS_RST;
			nspec_q <= NSPEC_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BINS_IN_USE:      nbins_q <= cfg_data[NBINS_W-1:0];
				REG_SPECTRA_PER_DUMP: nspec_q <= cfg_data[CNT_W-1:0];
				default:              ;
			endcase
		end
	end

	// every transaction in flight reserves a fifo slot so the pipeline never stalls
	assign occ      = {1'b0, fifo_cnt} + OCC_W'(v_s1) + OCC_W'(v_s2) + OCC_W'(v_s3);
	assign in_ready = !busy && (occ < OCC_W'(FIFO_DEPTH));
	assign accept   = in_valid && in_ready;

	tixc_seq #(.MAX_BINS(MAX_BINS)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.nbins  (nbins_q),
		.nspec  (nspec_q),
		.bin    (bin),
		.tag    (tag)
	);

	tixc_mult #(.MAX_BINS(MAX_BINS)) u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.smp      (in_data),
		.bin      (bin),
		.tag      (tag),
		.v_s1     (v_s1),
		.v_s2     (v_s2),
		.bin_s2   (bin_s2),
		.tag_s2   (tag_s2),
		.terms_s2 (terms_s2)
	);

	tixc_accum #(.MAX_BINS(MAX_BINS)) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s2     (v_s2),
		.bin_s2   (bin_s2),
		.tag_s2   (tag_s2),
		.terms_s2 (terms_s2),
		.v_s3     (v_s3),
		.push     (push),
		.res      (res),
		.busy     (busy)
	);

	tixc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.count     (fifo_cnt)
	);

endmodule
